FILE: design/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int QONE = 16384;
  localparam int RAD_W = 19;
  localparam int ROOT_W = 19;
  localparam int DIFF_W = 18;
  localparam int NUM_W = 33;
  localparam int QUO_W = 34;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;
  localparam int FIFO_CW = 3;

  typedef logic signed [15:0] elem_t;

  // Job handed from the front end to the back end.
  typedef struct packed {
    logic [RAD_W-1:0]         rad;
    logic [1:0]               diag_sel;
    logic signed [DIFF_W-1:0] d_x;
    logic signed [DIFF_W-1:0] d_y;
    logic signed [DIFF_W-1:0] d_z;
    logic signed [DIFF_W-1:0] d_w;
  } job_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
    logic               zero;
  } quat_t;

  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;
  localparam logic [1:0] SEL_W = 2'd3;

endpackage

FILE: design/rotation_matrix_to_quaternion_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Shoemake matrix to quaternion conversion, Q2.14 in and out.
//
// Channel  Ports                         Word
// in       in_valid/in_ready/in_elem_*   nine matrix elements
// out      out_valid/out_ready/out_*     quaternion and zero_root flag
//
// One word per cycle sustained while out_ready stays high. Path from input
// accept to out_valid: front register, queue, back-end input register, 19 root
// stages, divider entry stage, 34 bit-per-stage divider stages and the output register.
// Synchronous active-low reset empties the pipeline and queue.
// Output stall freezes the back end; the queue absorbs front-end words.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_elem_0_0, in_elem_0_1, in_elem_0_2,
  input  logic signed [15:0] in_elem_1_0, in_elem_1_1, in_elem_1_2,
  input  logic signed [15:0] in_elem_2_0, in_elem_2_1, in_elem_2_2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_quat_x, out_quat_y, out_quat_z, out_quat_w,
  output logic        out_zero_root
);

  logic f_vld, f_rdy, b_vld, b_rdy;
  rmq_pkg::job_t f_job, b_job;
  rmq_pkg::quat_t res;

  rmq_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .m00(in_elem_0_0), .m01(in_elem_0_1), .m02(in_elem_0_2),
    .m10(in_elem_1_0), .m11(in_elem_1_1), .m12(in_elem_1_2),
    .m20(in_elem_2_0), .m21(in_elem_2_1), .m22(in_elem_2_2),
    .job_valid(f_vld), .job_ready(f_rdy), .job(f_job)
  );

  rmq_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_vld), .wr_ready(f_rdy), .wr_data(f_job),
    .rd_valid(b_vld), .rd_ready(b_rdy), .rd_data(b_job)
  );

  rmq_back u_back (
    .clk, .rst_n, .job_valid(b_vld), .job_ready(b_rdy), .job(b_job),
    .out_valid, .out_ready, .res
  );

  assign out_quat_x = res.x;
  assign out_quat_y = res.y;
  assign out_quat_z = res.z;
  assign out_quat_w = res.w;
  assign out_zero_root = res.zero;

endmodule

FILE: design/rmq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front
// Trace test, axis pick, radicand and component numerators.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rmq_pkg::elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic          job_valid,
  input  logic          job_ready,
  output rmq_pkg::job_t job
);

  logic signed [17:0] tr;
  logic signed [19:0] rad_s;
  logic [1:0] axis;
  rmq_pkg::job_t job_nxt, job_r;
  logic vld_r;

  always_comb begin
    tr = 18'(m00) + 18'(m11) + 18'(m22);
    job_nxt = '0;
    axis = rmq_pkg::SEL_X;
    rad_s = '0;
    if (tr > 0) begin
      rad_s = 20'(tr) + 20'(rmq_pkg::QONE);
      job_nxt.diag_sel = rmq_pkg::SEL_W;
      job_nxt.d_x = 18'(m12) - 18'(m21);
      job_nxt.d_y = 18'(m20) - 18'(m02);
      job_nxt.d_z = 18'(m01) - 18'(m10);
    end else begin
      if (m11 > m00) axis = rmq_pkg::SEL_Y;
      if ((axis == rmq_pkg::SEL_Y) ? (m22 > m11) : (m22 > m00)) axis = rmq_pkg::SEL_Z;
      job_nxt.diag_sel = axis;
      job_nxt.d_x = 18'(m01) + 18'(m10);
      job_nxt.d_y = 18'(m01) + 18'(m10);
      job_nxt.d_z = 18'(m02) + 18'(m20);
      job_nxt.d_w = 18'(m12) - 18'(m21);
      case (axis)
        rmq_pkg::SEL_X: begin
          rad_s = 20'(m00) - 20'(m11) - 20'(m22) + 20'(rmq_pkg::QONE);
          job_nxt.d_y = 18'(m01) + 18'(m10);
          job_nxt.d_z = 18'(m02) + 18'(m20);
          job_nxt.d_w = 18'(m12) - 18'(m21);
        end
        rmq_pkg::SEL_Y: begin
          rad_s = 20'(m11) - 20'(m22) - 20'(m00) + 20'(rmq_pkg::QONE);
          job_nxt.d_z = 18'(m12) + 18'(m21);
          job_nxt.d_x = 18'(m10) + 18'(m01);
          job_nxt.d_w = 18'(m20) - 18'(m02);
        end
        default: begin
          rad_s = 20'(m22) - 20'(m00) - 20'(m11) + 20'(rmq_pkg::QONE);
          job_nxt.d_x = 18'(m20) + 18'(m02);
          job_nxt.d_y = 18'(m21) + 18'(m12);
          job_nxt.d_w = 18'(m01) - 18'(m10);
        end
      endcase
    end
    job_nxt.rad = rad_s[19] ? '0 : rad_s[18:0];
  end

  assign in_ready = !vld_r || job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (in_ready) vld_r <= in_valid;
    if (in_ready && in_valid) job_r <= job_nxt;
  end

  assign job_valid = vld_r;
  assign job = job_r;

endmodule

FILE: design/rmq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_fifo
// Small job queue between front and back ends.
// ----------------------------------------------------------------------------
module rmq_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  rmq_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output rmq_pkg::job_t rd_data
);

  rmq_pkg::job_t mem_r [rmq_pkg::FIFO_DEPTH];
  logic [rmq_pkg::FIFO_AW-1:0] wp_r, rp_r;
  logic [rmq_pkg::FIFO_CW-1:0] cnt_r;
  logic wr, rd;

  function automatic logic [rmq_pkg::FIFO_CW-1:0] FIFO_inc(input logic b);
    return {{(rmq_pkg::FIFO_CW-1){1'b0}}, b};
  endfunction

  assign wr_ready = cnt_r != rmq_pkg::FIFO_CW'(rmq_pkg::FIFO_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + FIFO_inc(wr) - FIFO_inc(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

FILE: design/rmq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, three-way division and saturation.
// Root: 19 stages, one result bit each. Division: 34 stages, one bit each.
// ----------------------------------------------------------------------------
module rmq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  rmq_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output rmq_pkg::quat_t res
);

  localparam int RS = rmq_pkg::ROOT_W;
  localparam int DS = rmq_pkg::QUO_W;
  localparam int NS = RS + DS + 1;
  localparam int SQ_W = 2 * RS;
  localparam int RMW = RS + 2;
  localparam int DW = rmq_pkg::DIFF_W;

  typedef struct packed {
    logic [1:0] sel;
    logic [3:0] neg;
    logic signed [DW-1:0] dw, dx, dy, dz;
  } ctl_t;

  logic adv;
  logic vld_r [NS+1];
  ctl_t ctl_r [NS+1];

  // root stages
  logic [SQ_W-1:0] sn_r [RS+1];
  logic [RS-1:0]   sq_r [RS+1];
  logic [RMW-1:0]  sr_r [RS+1];

  // divide stages: three lanes
  logic [RS-1:0]   dr_r [DS+1];
  logic [rmq_pkg::NUM_W-1:0] num_r [DS+1][3];
  logic [DS-1:0]   quo_r [DS+1][3];
  logic [RS:0]     rem_r [DS+1][3];

  rmq_pkg::quat_t res_r;
  logic res_vld_r;

  assign adv = !res_vld_r || out_ready;
  assign job_ready = adv;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] d);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  function automatic logic signed [15:0] sat(input logic neg, input logic [DS-1:0] q);
    logic signed [DS+1:0] v;
    v = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NS; s++) vld_r[s] <= 1'b0;
      res_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= job_valid;
      for (int s = 1; s <= NS; s++) vld_r[s] <= vld_r[s-1];
      res_vld_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    logic [RMW-1:0] trial;
    logic [RS:0] rm;
    logic [RS-1:0] rt;
    logic [RS-1:0] r;
    if (adv) begin
      ctl_r[0].sel <= job.diag_sel;
      ctl_r[0].dx <= job.d_x;
      ctl_r[0].dy <= job.d_y;
      ctl_r[0].dz <= job.d_z;
      ctl_r[0].dw <= job.d_w;
      ctl_r[0].neg <= {job.d_w[DW-1], job.d_z[DW-1], job.d_y[DW-1], job.d_x[DW-1]};
      for (int s = 1; s <= NS; s++) ctl_r[s] <= ctl_r[s-1];
      sn_r[0] <= {1'b0, job.rad, 18'd0};
      sq_r[0] <= '0;
      sr_r[0] <= '0;
      for (int s = 0; s < RS; s++) begin
        trial = {sr_r[s][RMW-3:0], sn_r[s][SQ_W-1 -: 2]};
        if (trial >= RMW'({sq_r[s], 2'b01})) begin
          sr_r[s+1] <= trial - RMW'({sq_r[s], 2'b01});
          sq_r[s+1] <= {sq_r[s][RS-2:0], 1'b1};
        end else begin
          sr_r[s+1] <= trial;
          sq_r[s+1] <= {sq_r[s][RS-2:0], 1'b0};
        end
        sn_r[s+1] <= {sn_r[s][SQ_W-3:0], 2'b00};
      end
      // divider entry: numerator = |D|<<15 + r>>1
      r = sq_r[RS];
      dr_r[0] <= r;
      for (int l = 0; l < 3; l++) begin
        logic signed [DW-1:0] d;
        d = (l == 0) ? ctl_r[RS].dx : (l == 1) ? ctl_r[RS].dy : ctl_r[RS].dz;
        if (ctl_r[RS].sel != rmq_pkg::SEL_W && l == 32'(ctl_r[RS].sel))
          d = ctl_r[RS].dw;
        num_r[0][l] <= ({15'd0, mag(d)} << 15) + rmq_pkg::NUM_W'(r >> 1);
        quo_r[0][l] <= '0;
        rem_r[0][l] <= '0;
      end
      for (int s = 0; s < DS; s++) begin
        dr_r[s+1] <= dr_r[s];
        for (int l = 0; l < 3; l++) begin
          rm = {rem_r[s][l][RS-1:0], (s >= DS - rmq_pkg::NUM_W) ?
                num_r[s][l][rmq_pkg::NUM_W-1] : 1'b0};
          if (rm >= {1'b0, dr_r[s]} && dr_r[s] != '0) begin
            rem_r[s+1][l] <= rm - {1'b0, dr_r[s]};
            quo_r[s+1][l] <= {quo_r[s][l][DS-2:0], 1'b1};
          end else begin
            rem_r[s+1][l] <= rm;
            quo_r[s+1][l] <= {quo_r[s][l][DS-2:0], 1'b0};
          end
          num_r[s+1][l] <= (s >= DS - rmq_pkg::NUM_W) ?
                           {num_r[s][l][rmq_pkg::NUM_W-2:0], 1'b0} : num_r[s][l];
        end
      end
      rt = dr_r[DS];
      if (vld_r[NS]) begin
        logic signed [15:0] c [3];
        logic [3:0] ng;
        logic signed [15:0] dg;
        ng = ctl_r[NS].neg;
        for (int l = 0; l < 3; l++) begin
          logic nl;
          nl = ng[l];
          if (ctl_r[NS].sel != rmq_pkg::SEL_W && l == 32'(ctl_r[NS].sel))
            nl = ng[3];
          c[l] = sat(nl, quo_r[DS][l]);
        end
        dg = (RS'(rt + 19'd4) >> 3) > 32767 ? 16'sh7fff : 16'(RS'(rt + 19'd4) >> 3);
        res_r.zero <= (rt == '0);
        if (rt == '0) begin
          res_r.x <= '0; res_r.y <= '0; res_r.z <= '0; res_r.w <= '0;
        end else begin
          case (ctl_r[NS].sel)
            rmq_pkg::SEL_X: begin
              res_r.x <= dg; res_r.y <= c[1]; res_r.z <= c[2]; res_r.w <= c[0];
            end
            rmq_pkg::SEL_Y: begin
              res_r.x <= c[0]; res_r.y <= dg; res_r.z <= c[2]; res_r.w <= c[1];
            end
            rmq_pkg::SEL_Z: begin
              res_r.x <= c[0]; res_r.y <= c[1]; res_r.z <= dg; res_r.w <= c[2];
            end
            default: begin
              res_r.x <= c[0]; res_r.y <= c[1]; res_r.z <= c[2]; res_r.w <= dg;
            end
          endcase
        end
      end
    end
  end

  assign out_valid = res_vld_r;
  assign res = res_r;

endmodule
